FILE: rtl/pal_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the positional array list.
package pal_pkg;

  localparam int KEY_BITS = 16;

  typedef enum logic [2:0] {
    FN_CREATE    = 3'd0,
    FN_DESTROY   = 3'd1,
    FN_INSERT    = 3'd2,
    FN_DELETE    = 3'd3,
    FN_REPLACE   = 3'd4,
    FN_RETRIEVE  = 3'd5,
    FN_FIND_KEY  = 3'd6,
    FN_FIND_ENTRY = 3'd7
  } func_t;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BADPOS     = 3'd1;
  localparam logic [2:0] ST_NOTCREATED = 3'd2;
  localparam logic [2:0] ST_NOTFOUND   = 3'd3;
  localparam logic [2:0] ST_FULL       = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_FIN  = 3'b100
  } state_t;

endpackage

FILE: rtl/positional_array_list.sv
`timescale 1ns / 1ps
// Positional array list: command sequencer over a single-port-pair entry store.
//
// Usage: drive in_func, in_position, in_entry_key and in_entry_payload and raise
// start while busy is low; the command word is taken at that clock edge and busy
// stays high until the sequence finishes. Exactly one result word follows per
// command: out_valid is high for one cycle with out_status, out_key, out_payload,
// out_found, out_found_index, out_count, out_is_empty and out_is_full.
// Steps per command, with n entries held:
//   create, destroy, replace and any refused command: straight to the finish
//   insert at p: moves entries n-1 down to p up one place (none when p equals n)
//   delete at p: reads p, then moves entries p+1 to n-1 down one; retrieve: reads p
//   search: walks from entry 0 up to n-1, stopping after the first match
// Every shift step is one read and one write of the entry store, a search step a
// read only; busy stays high over the walk, so a new command waits until it ends.
// A new command may be accepted in the cycle that out_valid is high.
// Reset empties the list and clears the created flag; the store is not cleared.
// The receiver cannot stall: each result word is shown for one cycle only.
module positional_array_list #(
  parameter int DEPTH        = 64,
  parameter int PAYLOAD_BITS = 48
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [2:0]                       in_func,
  input  logic [$clog2(DEPTH+1)-1:0]       in_position,
  input  logic [pal_pkg::KEY_BITS-1:0]     in_entry_key,
  input  logic [PAYLOAD_BITS-1:0]          in_entry_payload,
  output logic                             out_valid,
  output logic [2:0]                       out_status,
  output logic [pal_pkg::KEY_BITS-1:0]     out_key,
  output logic [PAYLOAD_BITS-1:0]          out_payload,
  output logic                             out_found,
  output logic [$clog2(DEPTH)-1:0]         out_found_index,
  output logic [$clog2(DEPTH+1)-1:0]       out_count,
  output logic                             out_is_empty,
  output logic                             out_is_full
);
  import pal_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = KEY_BITS + PAYLOAD_BITS;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);
  localparam logic [AW-1:0] STEP_A  = AW'(1);

  state_t                state_r, state_nxt;
  func_t                 op_r, op_nxt;
  logic [CW-1:0]         pos_r, pos_nxt;
  logic [KEY_BITS-1:0]   key_r, key_nxt;
  logic [PAYLOAD_BITS-1:0] pay_r, pay_nxt;
  logic [2:0]            status_r, status_nxt;
  logic [AW-1:0]         ptr_r, ptr_nxt;
  logic [AW-1:0]         last_r, last_nxt;
  logic [AW-1:0]         prev_r, prev_nxt;
  logic                  more_r, more_nxt;
  logic                  rd_vld_r, rd_vld_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic                  created_r, created_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [KEY_BITS-1:0]   okey_r, okey_nxt;
  logic [PAYLOAD_BITS-1:0] opay_r, opay_nxt;
  logic                  found_r, found_nxt;
  logic [AW-1:0]         fidx_r, fidx_nxt;

  logic [CW-1:0]         cnt_m1;
  logic [AW-1:0]         pos_a;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [EW-1:0]         mem_wdata;
  logic                  mem_re;
  logic [EW-1:0]         mem_rdata;
  logic [KEY_BITS-1:0]   rd_key;
  logic [PAYLOAD_BITS-1:0] rd_pay;
  logic                  hit;
  func_t                 in_op;

  assign cnt_m1 = cnt_r - ONE_C;
  assign pos_a  = pos_r[AW-1:0];
  assign in_op  = func_t'(in_func);
  assign rd_key = mem_rdata[EW-1:PAYLOAD_BITS];
  assign rd_pay = mem_rdata[PAYLOAD_BITS-1:0];

  pal_mem #(
    .DEPTH (DEPTH),
    .WIDTH (EW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (ptr_r),
    .rdata (mem_rdata)
  );

  pal_match #(
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_match (
    .op           (op_r),
    .want_key     (key_r),
    .want_payload (pay_r),
    .got_key      (rd_key),
    .got_payload  (rd_pay),
    .match        (hit)
  );

  // Store access: shift moves during the walk, the new entry at the end.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = prev_r;
    mem_wdata = mem_rdata;
    mem_re    = (state_r == S_SCAN) && more_r;
    case (state_r)
      S_SCAN: begin
        if (rd_vld_r) begin
          if (op_r == FN_INSERT) begin
            mem_we    = 1'b1;
            mem_waddr = prev_r + STEP_A;
          end else if (op_r == FN_DELETE && prev_r != pos_a) begin
            mem_we    = 1'b1;
            mem_waddr = prev_r - STEP_A;
          end
        end
      end
      S_FIN: begin
        if (status_r == ST_OK && (op_r inside {FN_INSERT, FN_REPLACE})) begin
          mem_we    = 1'b1;
          mem_waddr = pos_a;
          mem_wdata = {key_r, pay_r};
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    pos_nxt       = pos_r;
    key_nxt       = key_r;
    pay_nxt       = pay_r;
    status_nxt    = status_r;
    ptr_nxt       = ptr_r;
    last_nxt      = last_r;
    prev_nxt      = prev_r;
    more_nxt      = more_r;
    rd_vld_nxt    = 1'b0;
    cnt_nxt       = cnt_r;
    created_nxt   = created_r;
    out_valid_nxt = 1'b0;
    okey_nxt      = okey_r;
    opay_nxt      = opay_r;
    found_nxt     = found_r;
    fidx_nxt      = fidx_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt     = in_op;
          pos_nxt    = in_position;
          key_nxt    = in_entry_key;
          pay_nxt    = in_entry_payload;
          okey_nxt   = '0;
          opay_nxt   = '0;
          found_nxt  = 1'b0;
          fidx_nxt   = '0;
          more_nxt   = 1'b1;
          status_nxt = ST_OK;
          state_nxt  = S_FIN;
          if (in_op inside {FN_CREATE, FN_DESTROY}) begin
          end else if (!created_r) begin
            status_nxt = ST_NOTCREATED;
          end else begin
            case (in_op)
              FN_INSERT: begin
                if (cnt_r == DEPTH_C) begin
                  status_nxt = ST_FULL;
                end else if (in_position > cnt_r) begin
                  status_nxt = ST_BADPOS;
                end else if (in_position != cnt_r) begin
                  state_nxt = S_SCAN;
                  ptr_nxt   = cnt_m1[AW-1:0];
                  last_nxt  = in_position[AW-1:0];
                end
              end
              FN_FIND_KEY, FN_FIND_ENTRY: begin
                status_nxt = ST_NOTFOUND;
                if (cnt_r != '0) begin
                  state_nxt = S_SCAN;
                  ptr_nxt   = '0;
                  last_nxt  = cnt_m1[AW-1:0];
                end
              end
              default: begin
                if (in_position >= cnt_r) begin
                  status_nxt = ST_BADPOS;
                end else if (in_op == FN_DELETE) begin
                  state_nxt = S_SCAN;
                  ptr_nxt   = in_position[AW-1:0];
                  last_nxt  = cnt_m1[AW-1:0];
                end else if (in_op == FN_RETRIEVE) begin
                  state_nxt = S_SCAN;
                  ptr_nxt   = in_position[AW-1:0];
                  last_nxt  = in_position[AW-1:0];
                end
              end
            endcase
          end
        end
      end
      S_SCAN: begin
        if (more_r) begin
          rd_vld_nxt = 1'b1;
          prev_nxt   = ptr_r;
          if (ptr_r == last_r) begin
            more_nxt = 1'b0;
          end else if (op_r == FN_INSERT) begin
            ptr_nxt = ptr_r - STEP_A;
          end else begin
            ptr_nxt = ptr_r + STEP_A;
          end
        end
        if (rd_vld_r && (op_r inside {FN_DELETE, FN_RETRIEVE}) && prev_r == pos_a) begin
          okey_nxt = rd_key;
          opay_nxt = rd_pay;
        end
        if (rd_vld_r && (op_r inside {FN_FIND_KEY, FN_FIND_ENTRY}) && hit) begin
          found_nxt  = 1'b1;
          fidx_nxt   = prev_r;
          status_nxt = ST_OK;
          state_nxt  = S_FIN;
        end else if (!more_r) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
        case (op_r)
          FN_CREATE: begin
            created_nxt = 1'b1;
            cnt_nxt     = '0;
          end
          FN_DESTROY: begin
            created_nxt = 1'b0;
            cnt_nxt     = '0;
          end
          FN_INSERT: begin
            if (status_r == ST_OK) begin
              cnt_nxt = cnt_r + ONE_C;
            end
          end
          FN_DELETE: begin
            if (status_r == ST_OK) begin
              cnt_nxt = cnt_m1;
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      more_r      <= 1'b0;
      rd_vld_r    <= 1'b0;
      cnt_r       <= '0;
      created_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      more_r      <= more_nxt;
      rd_vld_r    <= rd_vld_nxt;
      cnt_r       <= cnt_nxt;
      created_r   <= created_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    pos_r    <= pos_nxt;
    key_r    <= key_nxt;
    pay_r    <= pay_nxt;
    status_r <= status_nxt;
    ptr_r    <= ptr_nxt;
    last_r   <= last_nxt;
    prev_r   <= prev_nxt;
    okey_r   <= okey_nxt;
    opay_r   <= opay_nxt;
    found_r  <= found_nxt;
    fidx_r   <= fidx_nxt;
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_key         = okey_r;
  assign out_payload     = opay_r;
  assign out_found       = found_r;
  assign out_found_index = fidx_r;
  assign out_count       = cnt_r;
  assign out_is_empty    = (cnt_r == '0);
  assign out_is_full     = (cnt_r == DEPTH_C);

  a_valid_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == S_FIN))
    else $error("result word without a finishing step");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("command word taken but sequencer not busy");

  a_port_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && mem_re) |-> (mem_waddr != ptr_r))
    else $error("shift writes the entry being read");

  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_found) |-> (out_status == ST_OK && out_count != '0))
    else $error("match reported with bad status or empty list");

endmodule

FILE: rtl/pal_mem.sv
`timescale 1ns / 1ps
// Entry store: one write port and one registered read port.
module pal_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/pal_match.sv
`timescale 1ns / 1ps
// Shared entry compare unit for key and whole-entry searches.
module pal_match #(
  parameter int PAYLOAD_BITS = 48
) (
  input  pal_pkg::func_t                op,
  input  logic [pal_pkg::KEY_BITS-1:0]  want_key,
  input  logic [PAYLOAD_BITS-1:0]       want_payload,
  input  logic [pal_pkg::KEY_BITS-1:0]  got_key,
  input  logic [PAYLOAD_BITS-1:0]       got_payload,
  output logic                          match
);
  import pal_pkg::*;

  logic key_eq;
  logic pay_eq;

  assign key_eq = (want_key == got_key);
  assign pay_eq = (want_payload == got_payload);
  assign match  = key_eq && ((op == FN_FIND_KEY) || pay_eq);

endmodule

FILE: dv/tb_positional_array_list.sv
`timescale 1ns / 1ps
// Self-checking testbench for the positional array list: directed table, then random command words.
module tb_positional_array_list;
  import pal_pkg::*;

  localparam int DEPTH     = 64;
  localparam int PAY_BITS  = 48;
  localparam int POS_BITS  = $clog2(DEPTH + 1);
  localparam int IDX_BITS  = $clog2(DEPTH);
  localparam int N_RANDOM  = 1550;
  localparam int LIMIT     = 1000000;
  localparam int TAIL      = DEPTH + 8;

  typedef enum int {MODE_GROW, MODE_MIX, MODE_SHRINK} mode_t;

  typedef struct {
    func_t                  fn;
    logic [POS_BITS-1:0]    pos;
    logic [KEY_BITS-1:0]    key;
    logic [PAY_BITS-1:0]    pay;
  } cmd_t;

  typedef struct {
    logic [2:0]             status;
    logic [KEY_BITS-1:0]    key;
    logic [PAY_BITS-1:0]    pay;
    logic                   found;
    logic [IDX_BITS-1:0]    idx;
    logic [POS_BITS-1:0]    count;
    logic                   empty;
    logic                   full;
  } res_t;

  typedef struct {
    cmd_t c;
    bit   typed;
    res_t r;
  } cmd_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic [2:0]            in_func;
  logic [POS_BITS-1:0]   in_position;
  logic [KEY_BITS-1:0]   in_entry_key;
  logic [PAY_BITS-1:0]   in_entry_payload;
  logic                  out_valid;
  logic [2:0]            out_status;
  logic [KEY_BITS-1:0]   out_key;
  logic [PAY_BITS-1:0]   out_payload;
  logic                  out_found;
  logic [IDX_BITS-1:0]   out_found_index;
  logic [POS_BITS-1:0]   out_count;
  logic                  out_is_empty;
  logic                  out_is_full;

  logic [KEY_BITS-1:0]   list_keys [DEPTH];
  logic [PAY_BITS-1:0]   list_pays [DEPTH];
  int                    list_count;
  bit                    list_live;

  res_t                  pending_results [$];
  cmd_row_t              opening_rows [$];
  int                    errors;
  int                    cycles;
  bit                    idle_on;

  positional_array_list #(
    .DEPTH       (DEPTH),
    .PAYLOAD_BITS(PAY_BITS)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_func         (in_func),
    .in_position     (in_position),
    .in_entry_key    (in_entry_key),
    .in_entry_payload(in_entry_payload),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_key         (out_key),
    .out_payload     (out_payload),
    .out_found       (out_found),
    .out_found_index (out_found_index),
    .out_count       (out_count),
    .out_is_empty    (out_is_empty),
    .out_is_full     (out_is_full)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic res_t list_apply(cmd_t c);
    res_t                r;
    int                  i;
    bit                  hit;
    logic [IDX_BITS-1:0] pidx;
    r = '{default: '0};
    r.status = ST_OK;
    hit = 1'b0;
    pidx = c.pos[IDX_BITS-1:0];
    if (c.fn == FN_CREATE) begin
      list_live = 1'b1;
      list_count = 0;
    end else if (c.fn == FN_DESTROY) begin
      list_live = 1'b0;
      list_count = 0;
    end else if (!list_live) begin
      r.status = ST_NOTCREATED;
    end else if (c.fn == FN_INSERT) begin
      if (list_count >= DEPTH) begin
        r.status = ST_FULL;
      end else if (int'(c.pos) > list_count) begin
        r.status = ST_BADPOS;
      end else begin
        for (i = list_count; i > int'(c.pos); i--) begin
          list_keys[i] = list_keys[i-1];
          list_pays[i] = list_pays[i-1];
        end
        list_keys[pidx] = c.key;
        list_pays[pidx] = c.pay;
        list_count++;
      end
    end else if (c.fn == FN_FIND_KEY || c.fn == FN_FIND_ENTRY) begin
      r.status = ST_NOTFOUND;
      for (i = 0; i < list_count && !hit; i++) begin
        if (list_keys[i] == c.key && (c.fn == FN_FIND_KEY || list_pays[i] == c.pay)) begin
          hit = 1'b1;
          r.status = ST_OK;
          r.found = 1'b1;
          r.idx = IDX_BITS'(i);
        end
      end
    end else if (int'(c.pos) >= list_count) begin
      r.status = ST_BADPOS;
    end else if (c.fn == FN_DELETE) begin
      r.key = list_keys[pidx];
      r.pay = list_pays[pidx];
      for (i = int'(c.pos); i + 1 < list_count; i++) begin
        list_keys[i] = list_keys[i+1];
        list_pays[i] = list_pays[i+1];
      end
      list_count--;
    end else if (c.fn == FN_REPLACE) begin
      list_keys[pidx] = c.key;
      list_pays[pidx] = c.pay;
    end else begin
      r.key = list_keys[pidx];
      r.pay = list_pays[pidx];
    end
    r.count = POS_BITS'(list_count);
    r.empty = (list_count == 0);
    r.full  = (list_count == DEPTH);
    return r;
  endfunction

  function automatic cmd_row_t pred_row(func_t fn, int pos, logic [KEY_BITS-1:0] key,
                                        logic [PAY_BITS-1:0] pay);
    cmd_row_t w;
    w.c = '{fn, POS_BITS'(pos), key, pay};
    w.typed = 1'b0;
    w.r = '{default: '0};
    return w;
  endfunction

  function automatic cmd_row_t typed_row(func_t fn, int pos, logic [KEY_BITS-1:0] key,
                                         logic [PAY_BITS-1:0] pay, logic [2:0] st,
                                         logic [KEY_BITS-1:0] okey,
                                         logic [PAY_BITS-1:0] opay, int cnt);
    cmd_row_t w;
    w = pred_row(fn, pos, key, pay);
    w.typed = 1'b1;
    w.r = '{st, okey, opay, 1'b0, '0, POS_BITS'(cnt), cnt == 0, cnt == DEPTH};
    return w;
  endfunction

  function automatic cmd_t make_cmd(mode_t m);
    cmd_t        c;
    int          wt [8];
    int          r;
    int          i;
    int          lim;
    int          j;
    bit          picked;
    logic [63:0] w;
    case (m)
      MODE_GROW:   wt = '{0, 0, 88, 3, 3, 2, 2, 2};
      MODE_SHRINK: wt = '{0, 1, 10, 65, 6, 6, 6, 6};
      default:     wt = '{1, 1, 30, 25, 10, 10, 11, 12};
    endcase
    c.fn = FN_CREATE;
    r = $urandom_range(99);
    if (!list_live) begin
      c.fn = (r < 75) ? FN_CREATE : func_t'($urandom_range(7));
    end else begin
      picked = 1'b0;
      for (i = 0; i < 8; i++) begin
        if (!picked && r < wt[i]) begin
          c.fn = func_t'(i);
          picked = 1'b1;
        end else if (!picked) begin
          r -= wt[i];
        end
      end
    end
    lim = (c.fn == FN_INSERT) ? list_count : list_count - 1;
    r = $urandom_range(99);
    if (lim >= 0 && r < 10) begin
      c.pos = ($urandom_range(1) != 0) ? POS_BITS'(lim) : '0;
    end else if (lim >= 0 && r < 85) begin
      c.pos = POS_BITS'($urandom_range(lim));
    end else begin
      c.pos = POS_BITS'($urandom_range(127));
    end
    w = {$urandom, $urandom};
    r = $urandom_range(99);
    c.key = (r < 30) ? KEY_BITS'($urandom_range(7)) : (r < 38) ? '1 : w[63:48];
    r = $urandom_range(99);
    c.pay = (r < 20) ? PAY_BITS'($urandom_range(3)) : (r < 28) ? '1 : w[47:0];
    if ((c.fn == FN_FIND_KEY || c.fn == FN_FIND_ENTRY) && list_count > 0 &&
        $urandom_range(99) < 60) begin
      j = $urandom_range(list_count - 1);
      c.key = list_keys[j];
      if ($urandom_range(99) < 75) c.pay = list_pays[j];
    end
    return c;
  endfunction

  task automatic send_word(cmd_row_t w);
    bit   taken;
    res_t p;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      start            <= !idle_on || ($urandom_range(99) >= 19);
      in_func          <= w.c.fn;
      in_position      <= w.c.pos;
      in_entry_key     <= w.c.key;
      in_entry_payload <= w.c.pay;
      @(posedge clk);
      taken = start && !busy;
    end
    p = list_apply(w.c);
    pending_results.push_back(w.typed ? w.r : p);
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    res_t e;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word: expected none, actual status %0d",
                 $time, out_status);
      end else begin
        e = pending_results.pop_front();
        check_field("status", e.status, out_status);
        check_field("key", e.key, out_key);
        check_field("payload", e.pay, out_payload);
        check_field("found", e.found, out_found);
        check_field("found_index", e.idx, out_found_index);
        check_field("count", e.count, out_count);
        check_field("is_empty", e.empty, out_is_empty);
        check_field("is_full", e.full, out_is_full);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int    k;
    int    seg;
    int    quiet_lo;
    mode_t m;
    start = 1'b0;
    in_func = '0;
    in_position = '0;
    in_entry_key = '0;
    in_entry_payload = '0;
    rst_n = 1'b0;
    errors = 0;
    cycles = 0;
    list_count = 0;
    list_live = 1'b0;
    idle_on = 1'b1;

    opening_rows.push_back(typed_row(FN_RETRIEVE, 0, 0, 0, ST_NOTCREATED, 0, 0, 0));
    opening_rows.push_back(typed_row(FN_INSERT, 0, 1, 1, ST_NOTCREATED, 0, 0, 0));
    opening_rows.push_back(typed_row(FN_FIND_KEY, 0, 0, 0, ST_NOTCREATED, 0, 0, 0));
    opening_rows.push_back(typed_row(FN_DESTROY, 0, 0, 0, ST_OK, 0, 0, 0));
    opening_rows.push_back(typed_row(FN_CREATE, 0, 0, 0, ST_OK, 0, 0, 0));
    opening_rows.push_back(typed_row(FN_DELETE, 0, 0, 0, ST_BADPOS, 0, 0, 0));
    opening_rows.push_back(typed_row(FN_FIND_ENTRY, 0, 0, 0, ST_NOTFOUND, 0, 0, 0));
    opening_rows.push_back(typed_row(FN_INSERT, 1, 7, 7, ST_BADPOS, 0, 0, 0));
    opening_rows.push_back(typed_row(FN_INSERT, 0, '1, '1, ST_OK, 0, 0, 1));
    opening_rows.push_back(typed_row(FN_INSERT, 0, 0, 0, ST_OK, 0, 0, 2));
    opening_rows.push_back(pred_row(FN_INSERT, 2, 16'h1234, 48'h0123_4567_89AB));
    opening_rows.push_back(pred_row(FN_INSERT, 1, 16'h8000, 48'h8000_0000_0000));
    opening_rows.push_back(typed_row(FN_RETRIEVE, 0, 0, 0, ST_OK, 0, 0, 4));
    opening_rows.push_back(typed_row(FN_RETRIEVE, 2, 0, 0, ST_OK, '1, '1, 4));
    opening_rows.push_back(pred_row(FN_REPLACE, 3, 16'hAAAA, 48'h5555_5555_5555));
    opening_rows.push_back(pred_row(FN_FIND_KEY, 0, '1, 0));
    opening_rows.push_back(pred_row(FN_FIND_ENTRY, 0, '1, 0));
    opening_rows.push_back(pred_row(FN_FIND_ENTRY, 0, 16'hAAAA, 48'h5555_5555_5555));
    opening_rows.push_back(typed_row(FN_DELETE, 2, 0, 0, ST_OK, '1, '1, 3));
    opening_rows.push_back(typed_row(FN_REPLACE, 3, 1, 1, ST_BADPOS, 0, 0, 3));
    opening_rows.push_back(typed_row(FN_RETRIEVE, 127, 0, 0, ST_BADPOS, 0, 0, 3));
    opening_rows.push_back(typed_row(FN_INSERT, 64, 2, 2, ST_BADPOS, 0, 0, 3));
    opening_rows.push_back(pred_row(FN_DELETE, 0, 0, 0));
    opening_rows.push_back(typed_row(FN_CREATE, 0, 0, 0, ST_OK, 0, 0, 0));
    opening_rows.push_back(typed_row(FN_DESTROY, 0, 0, 0, ST_OK, 0, 0, 0));

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    foreach (opening_rows[k]) send_word(opening_rows[k]);
    drain();

    quiet_lo = $urandom_range(900, 300);
    for (k = 0; k < N_RANDOM; k++) begin
      idle_on = !(k >= quiet_lo && k < quiet_lo + 300);
      if (k == 700) drain();
      seg = (k / 80) % 4;
      m = (seg == 0) ? MODE_GROW : (seg == 2) ? MODE_SHRINK : MODE_MIX;
      send_word('{make_cmd(m), 1'b0, '{default: '0}});
    end

    drain();
    repeat (TAIL) @(posedge clk);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
